### rtl/core/modbus_frame_crc_check_macros.svh
// Assertion macros used by the frame checker RTL.
`ifndef MODBUS_FRAME_CRC_CHECK_MACROS_SVH
`define MODBUS_FRAME_CRC_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mfcc_pkg.sv
`default_nettype none

package mfcc_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CrcWidth    = 16;
   localparam int unsigned LimitWidth  = 12;
   localparam int unsigned CountWidth  = 13;

   localparam logic [CrcWidth-1:0]   CrcStart   = 16'hFFFF;
   localparam logic [CrcWidth-1:0]   CrcPoly    = 16'hA001;
   localparam logic [LimitWidth-1:0] LimitReset = 12'd1000;
   localparam logic [CountWidth-1:0] MinLength  = 13'd3;
   localparam logic [CountWidth-1:0] CheckBytes = 13'd2;

   typedef logic [CrcWidth-1:0]   crc_type;
   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [LimitWidth-1:0] limit_type;

   // Reflected CRC-16 update over one byte, unrolled bitwise.
   function automatic crc_type crc_feed(input crc_type crc, input byte_type data);
      crc_type c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/modbus_frame_crc_check.sv
`default_nettype none
// Modbus RTU frame checker. Feed a frame one byte per transfer on req_, with
// req_tlast on its final byte; every frame yields exactly one result transfer
// on rsp_, from the cycle after that final byte is taken. The CRC-16/MODBUS
// is taken over all bytes but the last two, which are read as the received
// check value, low byte first. frame_ok needs a length from 3 up to the limit
// in csr_data and matching check values; length_bad flags the length alone.
// The block takes one byte every cycle unless a result is held on a stalled
// rsp_ side: the whole byte-wide CRC update is combinational between the
// input handshake and the state and result registers. A result waiting on a
// stalled rsp_ side holds off req_ only when it is not taken in that same
// cycle. A limit write takes effect from the next byte; write it between frames.

`include "modbus_frame_crc_check_macros.svh"

module modbus_frame_crc_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_data,     // max_frame_length
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // data_byte
   input  wire logic        req_tlast,    // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata     // frame_ok, length_bad, computed_crc,
                                          // received_crc, zero fill
);

   mfcc_pkg::limit_type limit_ff, limit_in;
   mfcc_pkg::crc_type   crc_ff, crc_in;
   mfcc_pkg::byte_type  older_ff, older_in;
   mfcc_pkg::byte_type  newer_ff, newer_in;
   mfcc_pkg::count_type count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff, ok_in;
   logic                bad_ff, bad_in;
   mfcc_pkg::crc_type   comp_ff, comp_in;
   mfcc_pkg::crc_type   rx_ff, rx_in;

   logic                req_xfer;
   logic                last_xfer;
   mfcc_pkg::crc_type   crc_next;
   mfcc_pkg::count_type count_next;
   mfcc_pkg::count_type limit_ext;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign last_xfer  = req_xfer && req_tlast;
   assign limit_ext  = {1'b0, limit_ff};

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
   end

   always_comb begin
      crc_next = crc_ff;
      if (count_ff >= mfcc_pkg::CheckBytes) begin
         crc_next = mfcc_pkg::crc_feed(crc_ff, older_ff);
      end
      count_next = count_ff;
      if (count_ff <= limit_ext) begin
         count_next = count_ff + 1'b1;
      end

      rx_in   = {req_tdata, newer_ff};
      comp_in = crc_next;
      bad_in  = (count_next < mfcc_pkg::MinLength) || (count_next > limit_ext);
      ok_in   = !bad_in && (rx_in == crc_next);

      crc_in   = crc_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      count_in = count_ff;
      if (last_xfer) begin
         crc_in   = mfcc_pkg::CrcStart;
         older_in = '0;
         newer_in = '0;
         count_in = '0;
      end else if (req_xfer) begin
         crc_in   = crc_next;
         older_in = newer_ff;
         newer_in = req_tdata;
         count_in = count_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (last_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= mfcc_pkg::LimitReset;
         crc_ff       <= mfcc_pkg::CrcStart;
         older_ff     <= '0;
         newer_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         crc_ff       <= crc_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_xfer) begin
         ok_ff   <= ok_in;
         bad_ff  <= bad_in;
         comp_ff <= comp_in;
         rx_ff   <= rx_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rx_ff, comp_ff, bad_ff, ok_ff};

   `MFCC_ASSERT_NEXT(a_result_follows_last, clock, reset, last_xfer, rsp_valid_ff, "no result after final byte")
   `MFCC_ASSERT_NEXT(a_state_restarts, clock, reset, last_xfer, (count_ff == '0) && (crc_ff == mfcc_pkg::CrcStart), "frame state not restarted")
   `MFCC_ASSERT_NOW(a_ok_consistent, clock, reset, rsp_valid_ff && ok_ff, !bad_ff && (comp_ff == rx_ff), "frame_ok with bad length or mismatch")
   `MFCC_ASSERT_NEXT(a_count_advances, clock, reset, req_xfer && !req_tlast && (count_ff <= limit_ext), count_ff == $past(count_ff) + 1'b1, "byte count did not advance")

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;

   localparam int CycleLimit = 300000;
   localparam int DrainCycles = 4;

   typedef struct packed {
      logic              frame_ok;
      logic              length_bad;
      mfcc_pkg::crc_type computed_crc;
      mfcc_pkg::crc_type received_crc;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   verdict_type frame_verdicts[$];
   int          failures = 0;
   int          cycle_count = 0;
   int          sent_bytes = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   // Predictor state for the frame in progress.
   mfcc_pkg::crc_type   run_crc = mfcc_pkg::CrcStart;
   mfcc_pkg::byte_type  held_old = '0;
   mfcc_pkg::byte_type  held_new = '0;
   mfcc_pkg::count_type seen_count = '0;
   mfcc_pkg::limit_type frame_limit = mfcc_pkg::LimitReset;

   modbus_frame_crc_check uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic mfcc_pkg::crc_type modbus_crc_byte(input mfcc_pkg::crc_type c,
                                                         input mfcc_pkg::byte_type d);
      for (int i = 0; i < 8; i++) begin
         logic fb;
         fb = c[0] ^ d[i];
         c = c >> 1;
         if (fb) begin
            c = c ^ mfcc_pkg::CrcPoly;
         end
      end
      return c;
   endfunction

   task automatic track_frame_byte(input mfcc_pkg::byte_type d, input logic last);
      verdict_type       v;
      mfcc_pkg::crc_type rx;
      logic              bad;
      if (seen_count >= mfcc_pkg::CheckBytes) begin
         run_crc = modbus_crc_byte(run_crc, held_old);
      end
      held_old = held_new;
      held_new = d;
      if (seen_count <= {1'b0, frame_limit}) begin
         seen_count = seen_count + 1'b1;
      end
      if (last) begin
         rx = {held_new, held_old};
         bad = (seen_count < mfcc_pkg::MinLength) || (seen_count > {1'b0, frame_limit});
         v.frame_ok = !bad && (rx == run_crc);
         v.length_bad = bad;
         v.computed_crc = run_crc;
         v.received_crc = rx;
         frame_verdicts.push_back(v);
         run_crc = mfcc_pkg::CrcStart;
         held_old = '0;
         held_new = '0;
         seen_count = '0;
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.frame_ok = rsp_tdata[0];
         got.length_bad = rsp_tdata[1];
         got.computed_crc = rsp_tdata[17:2];
         got.received_crc = rsp_tdata[33:18];
         if (frame_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            failures++;
         end else begin
            want = frame_verdicts.pop_front();
            if (got.frame_ok !== want.frame_ok) begin
               $display("%0t: frame_ok expected %0b got %0b", $time,
                        want.frame_ok, got.frame_ok);
               failures++;
            end
            if (got.length_bad !== want.length_bad) begin
               $display("%0t: length_bad expected %0b got %0b", $time,
                        want.length_bad, got.length_bad);
               failures++;
            end
            if (got.computed_crc !== want.computed_crc) begin
               $display("%0t: computed_crc expected %h got %h", $time,
                        want.computed_crc, got.computed_crc);
               failures++;
            end
            if (got.received_crc !== want.received_crc) begin
               $display("%0t: received_crc expected %h got %h", $time,
                        want.received_crc, got.received_crc);
               failures++;
            end
         end
      end
   end

   task automatic send_byte(input mfcc_pkg::byte_type d, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
      track_frame_byte(d, last);
   endtask

   // Send body, optionally followed by its check value, low byte first, with one bit of it optionally flipped.
   task automatic send_frame(input mfcc_pkg::byte_type body[$], input bit add_crc,
                             input bit corrupt);
      mfcc_pkg::crc_type c;
      c = mfcc_pkg::CrcStart;
      foreach (body[i]) begin
         c = modbus_crc_byte(c, body[i]);
      end
      if (corrupt) begin
         c = c ^ (16'd1 << $urandom_range(15));
      end
      foreach (body[i]) begin
         send_byte(body[i], !add_crc && (i == body.size() - 1));
      end
      if (add_crc) begin
         send_byte(c[7:0], 1'b0);
         send_byte(c[15:8], 1'b1);
      end
   endtask

   task automatic wait_results;
      req_tvalid <= 1'b0;
      while (frame_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(input mfcc_pkg::limit_type v);
      wait_results();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      frame_limit = v;
   endtask

   task automatic test_short_frames;
      mfcc_pkg::byte_type body[$];
      body = '{8'h00};
      send_frame(body, 1'b0, 1'b0);
      body = '{8'hFF};
      send_frame(body, 1'b0, 1'b0);
      body = '{8'hFF, 8'h00};
      send_frame(body, 1'b0, 1'b0);
   endtask

   task automatic test_good_frames;
      mfcc_pkg::byte_type body[$];
      body = '{8'h00};
      send_frame(body, 1'b1, 1'b0);
      body = '{8'hFF, 8'hFF};
      send_frame(body, 1'b1, 1'b0);
      body = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A};
      send_frame(body, 1'b1, 1'b0);
      body = '{8'h55, 8'hAA};
      send_frame(body, 1'b1, 1'b1);
      body = '{8'h00, 8'h00, 8'h00};
      send_frame(body, 1'b0, 1'b0);
   endtask

   task automatic send_random_body(input int n, input bit add_crc, input bit corrupt);
      mfcc_pkg::byte_type body[$];
      for (int i = 0; i < n; i++) begin
         body.push_back(mfcc_pkg::byte_type'($urandom));
      end
      send_frame(body, add_crc, corrupt);
   endtask

   task automatic test_length_limits;
      write_limit(12'd4095);
      send_random_body(20, 1'b1, 1'b0);
      write_limit(12'd40);
      send_random_body(38, 1'b1, 1'b0);
      send_random_body(39, 1'b1, 1'b0);
      send_random_body(60, 1'b1, 1'b0);
      write_limit(12'd3);
      send_random_body(1, 1'b1, 1'b0);
      send_random_body(2, 1'b1, 1'b0);
      write_limit(12'd0);
      send_random_body(1, 1'b1, 1'b0);
      send_random_body(1, 1'b0, 1'b0);
      write_limit(12'd2);
      send_random_body(1, 1'b1, 1'b0);
      send_random_body(2, 1'b0, 1'b0);
      write_limit(mfcc_pkg::LimitReset);
   endtask

   // Mostly well-formed frames with random content, some broken or noise.
   task automatic test_random_frames(input int n);
      int stop_at;
      int kind;
      stop_at = sent_bytes + n;
      while (sent_bytes < stop_at) begin
         kind = $urandom_range(9);
         if (kind <= 6) begin
            send_random_body(($urandom_range(7) == 0) ? $urandom_range(1, 60)
                                                      : $urandom_range(1, 10),
                             1'b1, 1'b0);
         end else if (kind == 7) begin
            send_random_body($urandom_range(1, 12), 1'b1, 1'b1);
         end else if (kind == 8) begin
            send_random_body($urandom_range(1, 2), 1'b0, 1'b0);
         end else begin
            send_random_body($urandom_range(1, 40), 1'b0, 1'b0);
         end
      end
   endtask

   initial begin
      send_idle_pct = 11;
      recv_idle_pct = 78;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_frames();
      test_good_frames();
      test_random_frames(300);

      write_limit(mfcc_pkg::limit_type'($urandom_range(3, 20)));
      send_idle_pct = 78;
      recv_idle_pct = 11;
      test_random_frames(300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_length_limits();
      test_random_frames(130);
      write_limit(mfcc_pkg::limit_type'($urandom_range(3, 4095)));
      test_random_frames(130);

      wait_results();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
